/* hdl/rbfb_pkg.sv */
// Shared types and operation codes for the burst ring buffer FIFO.
// Depends on nothing; the sequencer, top level, checker and testbench refer to it by scoped names.
`timescale 1ns / 1ps

package rbfb_pkg;

   // Operation codes carried in the mode field
   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_PEEK  = 2'd2;
   localparam logic [1:0] MODE_SKIP  = 2'd3;

   // One input item
   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] write_data;
      logic [4:0]  count;
   } req_item_type;

   // One result item
   typedef struct packed {
      logic [31:0] read_data;
      logic        data_valid;
      logic        last;
      logic [4:0]  done_count;
      logic [6:0]  level;
   } rsp_item_type;

   // Result control from the sequencer; data is joined from the store
   typedef struct packed {
      logic       strobe;
      logic       data_valid;
      logic       last;
      logic [4:0] done_count;
      logic [6:0] level;
   } rsp_tag_type;

endpackage

/* hdl/rbfb_store.sv */
// Element store: one write port, one read port, registered read data.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps

module rbfb_store #(
   parameter int DEPTH      = 64,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [ELEM_WIDTH-1:0]    wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [ELEM_WIDTH-1:0]    rd_data
);

   logic [ELEM_WIDTH-1:0] mem [DEPTH];
   logic [ELEM_WIDTH-1:0] rd_data_ff;

   // Write an element
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read when enabled; hold the last word otherwise
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/rbfb_ctrl.sv */
// Sequencer: write and read counters, request clamping and burst stepping.
// Depends on rbfb_pkg; drives the ports of rbfb_store.
`timescale 1ns / 1ps

module rbfb_ctrl #(
   parameter int DEPTH     = 64,
   parameter int MAX_BURST = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  rbfb_pkg::req_item_type     req_data,
   output rbfb_pkg::rsp_tag_type      rsp_tag,
   output logic                       wr_en,
   output logic [$clog2(DEPTH)-1:0]   wr_addr,
   output logic                       rd_en,
   output logic [$clog2(DEPTH)-1:0]   rd_addr
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = AW + 1;
   localparam int NW = $clog2(MAX_BURST + 1);
   localparam int LW = (CW > 7) ? CW : 7;

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_BURST = 1'b1;

   logic                  state_ff,  state_in;
   logic [CW-1:0]         wr_ff,     wr_in;
   logic [CW-1:0]         rd_ff,     rd_in;
   logic [AW-1:0]         base_ff,   base_in;
   logic [NW-1:0]         idx_ff,    idx_in;
   logic [NW-1:0]         n_ff,      n_in;
   logic [6:0]            lvl_ff,    lvl_in;
   rbfb_pkg::rsp_tag_type tag_ff,    tag_in;

   logic [CW-1:0] occ;
   logic          full;
   logic [LW-1:0] req_ext;
   logic [LW-1:0] req_sat;
   logic [LW-1:0] occ_ext;
   logic [LW-1:0] n_wide;
   logic [NW-1:0] n;
   logic          accept;
   logic          burst_last;

   // Occupancy and the clamped request
   assign occ     = wr_ff - rd_ff;
   assign full    = occ[CW-1];
   assign req_ext = LW'(req_data.count);
   assign req_sat = (req_ext > LW'(MAX_BURST)) ? LW'(MAX_BURST) : req_ext;
   assign occ_ext = LW'(occ);
   assign n_wide  = (req_sat < occ_ext) ? req_sat : occ_ext;
   assign n       = NW'(n_wide);

   assign busy       = (state_ff == ST_BURST);
   assign accept     = start && !busy;
   assign burst_last = ((idx_ff + NW'(1)) == n_ff);

   // Decode an accepted item, or step through a burst
   always_comb begin
      state_in = state_ff;
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      base_in  = base_ff;
      idx_in   = idx_ff;
      n_in     = n_ff;
      lvl_in   = lvl_ff;
      tag_in   = '0;
      wr_en    = 1'b0;
      wr_addr  = AW'(wr_ff);
      rd_en    = 1'b0;
      rd_addr  = base_ff + AW'(idx_ff);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               tag_in.strobe = 1'b1;
               tag_in.last   = 1'b1;
               case (req_data.mode)
                  rbfb_pkg::MODE_WRITE: begin
                     if (!full) begin
                        wr_en             = 1'b1;
                        wr_in             = wr_ff + CW'(1);
                        tag_in.done_count = 5'd1;
                        tag_in.level      = 7'(occ + CW'(1));
                     end else begin
                        tag_in.level      = 7'(occ);
                     end
                  end
                  rbfb_pkg::MODE_SKIP: begin
                     rd_in             = rd_ff + CW'(n);
                     tag_in.done_count = 5'(n);
                     tag_in.level      = 7'(occ - CW'(n));
                  end
                  rbfb_pkg::MODE_READ,
                  rbfb_pkg::MODE_PEEK: begin
                     if (n == '0) begin
                        tag_in.level = 7'(occ);
                     end else begin
                        // Nothing shows now; the burst starts next cycle
                        tag_in   = '0;
                        state_in = ST_BURST;
                        base_in  = AW'(rd_ff);
                        idx_in   = '0;
                        n_in     = n;
                        if (req_data.mode == rbfb_pkg::MODE_READ) begin
                           rd_in  = rd_ff + CW'(n);
                           lvl_in = 7'(occ - CW'(n));
                        end else begin
                           lvl_in = 7'(occ);
                        end
                     end
                  end
                  default: begin
                     tag_in = '0;
                  end
               endcase
            end
         end
         ST_BURST: begin
            // Fetch one element a cycle; its tag lines up with the read data
            rd_en             = 1'b1;
            tag_in.strobe     = 1'b1;
            tag_in.data_valid = 1'b1;
            tag_in.last       = burst_last;
            tag_in.done_count = 5'(n_ff);
            tag_in.level      = lvl_ff;
            idx_in            = idx_ff + NW'(1);
            if (burst_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wr_ff    <= '0;
         rd_ff    <= '0;
         tag_ff   <= '0;
      end else begin
         state_ff <= state_in;
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         tag_ff   <= tag_in;
      end
   end

   // Burst bookkeeping
   always_ff @(posedge clock) begin
      base_ff <= base_in;
      idx_ff  <= idx_in;
      n_ff    <= n_in;
      lvl_ff  <= lvl_in;
   end

   assign rsp_tag = tag_ff;

endmodule

/* hdl/ring_buffer_fifo_burst.sv */
// Latency: write, skip and empty read or peek give one result the cycle after acceptance.
// A read or peek of n elements keeps busy high while its elements are fetched and gives one
// result a cycle, paced by the single read port of the store.
// Throughput: one single-result item a cycle; no new item is taken until a burst is fetched.
// Reset (synchronous) clears both counters and the sequencer; the store keeps its contents.
// The receiver cannot stall: each result shows for exactly one cycle under strobe.
`timescale 1ns / 1ps

module ring_buffer_fifo_burst #(
   parameter int DEPTH      = 64,
   parameter int ELEM_WIDTH = 32,
   parameter int MAX_BURST  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  rbfb_pkg::req_item_type req_data,
   output logic                   strobe,
   output rbfb_pkg::rsp_item_type rsp_data
);

   localparam int AW = $clog2(DEPTH);

   rbfb_pkg::rsp_tag_type rsp_tag;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [ELEM_WIDTH-1:0] rd_data;

   rbfb_ctrl #(
      .DEPTH     (DEPTH),
      .MAX_BURST (MAX_BURST)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_tag  (rsp_tag),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr)
   );

   rbfb_store #(
      .DEPTH      (DEPTH),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ELEM_WIDTH'(req_data.write_data)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Join the result tag with the element; zero the data on non-element results
   always_comb begin
      strobe              = rsp_tag.strobe;
      rsp_data.read_data  = rsp_tag.data_valid ? 32'(rd_data) : 32'd0;
      rsp_data.data_valid = rsp_tag.data_valid;
      rsp_data.last       = rsp_tag.last;
      rsp_data.done_count = rsp_tag.done_count;
      rsp_data.level      = rsp_tag.level;
   end

endmodule

/* hdl/rbfb_checker.sv */
// Port-level checks for the burst ring buffer FIFO, bound to the top level.
// Depends on rbfb_pkg and on the port names of ring_buffer_fifo_burst.
`timescale 1ns / 1ps

module rbfb_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input rbfb_pkg::req_item_type req_data,
   input logic                   strobe,
   input rbfb_pkg::rsp_item_type rsp_data
);

   // An accepted write answers next cycle with a single non-element result
   a_write_answer: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.mode == rbfb_pkg::MODE_WRITE)
      |=> strobe && rsp_data.last && !rsp_data.data_valid)
      else $error("write item not answered by one final result");

   // A burst runs without gaps up to its final item
   a_burst_gapless: assert property (@(posedge clock) disable iff (reset)
      strobe && !rsp_data.last |=> strobe && rsp_data.data_valid)
      else $error("gap inside a burst");

   // Within a burst the count and level stay put
   a_burst_steady: assert property (@(posedge clock) disable iff (reset)
      strobe && !rsp_data.last
      |=> $stable(rsp_data.done_count) && $stable(rsp_data.level))
      else $error("burst count or level changed mid-burst");

   // No new item is taken while a burst still has results to come
   a_burst_busy: assert property (@(posedge clock) disable iff (reset)
      strobe && !rsp_data.last |-> busy)
      else $error("ready while a burst is unfinished");

   // Only element results carry data
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      strobe && !rsp_data.data_valid |-> (rsp_data.read_data == 32'd0))
      else $error("non-element result carries data");

endmodule

bind ring_buffer_fifo_burst rbfb_checker u_rbfb_checker (.*);

/* tb/tb_ring_buffer_fifo_burst.sv */
// Self-checking testbench for the burst ring buffer FIFO: directed corner cases, two full/drain
// passes and a long random mix, all checked against an in-bench model of the FIFO.
// Depends on rbfb_pkg and ring_buffer_fifo_burst.
`timescale 1ns / 1ps

module tb_ring_buffer_fifo_burst;

   localparam int FIFO_DEPTH  = 64;
   localparam int BURST_LIMIT = 16;
   localparam int QUIET_LIMIT = 2000;
   localparam int TAIL_CYCLES = 20;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   rbfb_pkg::req_item_type req_data = '0;
   logic                   strobe;
   rbfb_pkg::rsp_item_type rsp_data;

   // Shadow of the FIFO state, advanced on every accepted item
   logic [31:0]  shadow_store [FIFO_DEPTH];
   logic [6:0]   shadow_wr = '0;
   logic [6:0]   shadow_rd = '0;

   rbfb_pkg::rsp_item_type due_results[$];
   int           error_count = 0;
   int           quiet_cycles = 0;

   ring_buffer_fifo_burst uut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .strobe   (strobe),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [6:0] shadow_fill();
      return shadow_wr - shadow_rd;
   endfunction

   // Advance the shadow FIFO by one item and queue the results it owes
   task automatic apply_fifo_op(input rbfb_pkg::req_item_type op);
      logic [6:0]   fill;
      logic [6:0]   first;
      logic [4:0]   n;
      logic [5:0]   idx;
      rbfb_pkg::rsp_item_type r;
      fill = shadow_fill();
      r = '0;
      r.last = 1'b1;
      if (op.mode == rbfb_pkg::MODE_WRITE) begin
         if (fill < FIFO_DEPTH) begin
            shadow_store[shadow_wr[5:0]] = op.write_data;
            shadow_wr = shadow_wr + 7'd1;
            r.done_count = 5'd1;
         end
         r.level = shadow_fill();
         due_results.push_back(r);
      end else begin
         // saturate to the burst limit, then clamp to occupancy
         n = (op.count > BURST_LIMIT) ? 5'(BURST_LIMIT) : op.count;
         if (n > fill) n = fill[4:0];
         first = shadow_rd;
         if (op.mode != rbfb_pkg::MODE_PEEK) shadow_rd = shadow_rd + 7'(n);
         r.done_count = n;
         r.level = shadow_fill();
         if (op.mode == rbfb_pkg::MODE_SKIP || n == 0) begin
            due_results.push_back(r);
         end else begin
            for (int i = 0; i < n; i++) begin
               idx = first[5:0] + 6'(i);
               r.read_data  = shadow_store[idx];
               r.data_valid = 1'b1;
               r.last       = (i == n - 1);
               due_results.push_back(r);
            end
         end
      end
   endtask

   // Present one item and hold it until the block takes it
   task automatic issue_op(input logic [1:0] mode, input logic [31:0] wdata,
                           input logic [4:0] cnt);
      rbfb_pkg::req_item_type op;
      op.mode = mode;
      op.write_data = wdata;
      op.count = cnt;
      @(negedge clock);
      start <= 1'b1;
      req_data <= op;
      do @(posedge clock); while (busy);
      apply_fifo_op(op);
   endtask

   function automatic int gap_length();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 85) return $urandom_range(1, 2);
      if (r < 97) return $urandom_range(3, 8);
      return $urandom_range(15, 40);
   endfunction

   // Drop start for a random stretch, with junk on the request bus
   task automatic pause_sender(input bit gaps_on);
      int          n;
      logic [63:0] junk;
      n = gaps_on ? gap_length() : 0;
      for (int i = 0; i < n; i++) begin
         @(negedge clock);
         junk = {$urandom, $urandom};
         start <= 1'b0;
         req_data <= junk[$bits(rbfb_pkg::req_item_type)-1:0];
      end
   endtask

   // Hold off until every owed result has come back
   task automatic await_drain();
      @(negedge clock);
      start <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] random_word();
      int r;
      r = $urandom_range(99);
      if (r < 8) return 32'h0000_0000;
      if (r < 16) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   function automatic logic [4:0] random_count();
      if ($urandom_range(99) < 85) return 5'($urandom_range(0, BURST_LIMIT));
      return 5'($urandom_range(BURST_LIMIT + 1, 31));
   endfunction

   // Requests on an empty buffer
   task automatic test_empty_requests();
      issue_op(rbfb_pkg::MODE_READ, 32'h0, 5'd0);
      issue_op(rbfb_pkg::MODE_READ, 32'hFFFF_FFFF, 5'd5);
      issue_op(rbfb_pkg::MODE_PEEK, 32'h0, 5'd3);
      issue_op(rbfb_pkg::MODE_SKIP, 32'h0, 5'd31);
      await_drain();
   endtask

   // Extreme data, each operation, clamping and oversized counts
   task automatic test_basic_ops();
      issue_op(rbfb_pkg::MODE_WRITE, 32'h0000_0000, 5'd0);
      issue_op(rbfb_pkg::MODE_WRITE, 32'hFFFF_FFFF, 5'd31);
      issue_op(rbfb_pkg::MODE_WRITE, 32'hAAAA_AAAA, 5'd0);
      issue_op(rbfb_pkg::MODE_WRITE, 32'h5555_5555, 5'd0);
      issue_op(rbfb_pkg::MODE_WRITE, 32'h0000_0001, 5'd16);
      issue_op(rbfb_pkg::MODE_WRITE, 32'h8000_0000, 5'd0);
      issue_op(rbfb_pkg::MODE_PEEK, 32'h0, 5'd16);
      issue_op(rbfb_pkg::MODE_PEEK, 32'h0, 5'd0);
      issue_op(rbfb_pkg::MODE_READ, 32'h0, 5'd2);
      issue_op(rbfb_pkg::MODE_SKIP, 32'h0, 5'd1);
      issue_op(rbfb_pkg::MODE_WRITE, 32'h1234_5678, 5'd31);
      issue_op(rbfb_pkg::MODE_READ, 32'h0, 5'd31);
      issue_op(rbfb_pkg::MODE_READ, 32'h0, 5'd1);
      issue_op(rbfb_pkg::MODE_SKIP, 32'h0, 5'd0);
      await_drain();
   endtask

   // Fill to full, push into a full buffer, then drain in bursts
   task automatic test_full_buffer();
      for (int pass = 0; pass < 2; pass++) begin
         while (shadow_fill() < FIFO_DEPTH) begin
            issue_op(rbfb_pkg::MODE_WRITE, random_word(), 5'($urandom));
            pause_sender(pass == 1);
         end
         issue_op(rbfb_pkg::MODE_WRITE, random_word(), 5'd0);
         issue_op(rbfb_pkg::MODE_WRITE, random_word(), 5'd0);
         issue_op(rbfb_pkg::MODE_PEEK, 32'h0, 5'd31);
         issue_op(rbfb_pkg::MODE_READ, 32'h0, 5'd16);
         issue_op(rbfb_pkg::MODE_SKIP, 32'h0, 5'd17);
         while (shadow_fill() != 0) begin
            issue_op(($urandom_range(3) == 0) ? rbfb_pkg::MODE_SKIP : rbfb_pkg::MODE_READ,
                     $urandom, 5'($urandom_range(1, 31)));
            pause_sender(pass == 0);
         end
      end
      await_drain();
   endtask

   // Random mix in segments of varying write bias, gaps on or off per segment
   task automatic test_random_mix();
      int          wr_pct;
      bit          gaps_on;
      logic [1:0]  mode;
      for (int seg = 0; seg < 10; seg++) begin
         case ($urandom_range(3))
            0: wr_pct = 20;
            1: wr_pct = 50;
            2: wr_pct = 75;
            default: wr_pct = 95;
         endcase
         gaps_on = ($urandom_range(9) < 7);
         for (int i = 0; i < 34; i++) begin
            if ($urandom_range(99) < wr_pct) mode = rbfb_pkg::MODE_WRITE;
            else mode = 2'($urandom_range(1, 3));
            issue_op(mode, random_word(), random_count());
            pause_sender(gaps_on);
         end
         if (seg == 4 || $urandom_range(2) == 0) await_drain();
      end
      await_drain();
   endtask

   // Compare each strobed result with the oldest owed one
   always @(posedge clock) begin
      rbfb_pkg::rsp_item_type want;
      if (!reset && strobe) begin
         if (due_results.size() == 0) begin
            $error("unexpected result: read_data %h last %b", rsp_data.read_data,
                   rsp_data.last);
            error_count++;
         end else begin
            want = due_results.pop_front();
            if (rsp_data.read_data !== want.read_data) begin
               $error("read_data expected %h got %h", want.read_data, rsp_data.read_data);
               error_count++;
            end
            if (rsp_data.data_valid !== want.data_valid) begin
               $error("data_valid expected %b got %b", want.data_valid, rsp_data.data_valid);
               error_count++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last expected %b got %b", want.last, rsp_data.last);
               error_count++;
            end
            if (rsp_data.done_count !== want.done_count) begin
               $error("done_count expected %0d got %0d", want.done_count,
                      rsp_data.done_count);
               error_count++;
            end
            if (rsp_data.level !== want.level) begin
               $error("level expected %0d got %0d", want.level, rsp_data.level);
               error_count++;
            end
         end
      end
   end

   // Stop the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("ring_buffer_fifo_burst test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_requests();
      test_basic_ops();
      test_full_buffer();
      test_random_mix();
      await_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("ring_buffer_fifo_burst test passed");
      end else begin
         $display("ring_buffer_fifo_burst test failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/rbfb_pkg.sv
hdl/rbfb_store.sv
hdl/rbfb_ctrl.sv
hdl/ring_buffer_fifo_burst.sv
hdl/rbfb_checker.sv
tb/tb_ring_buffer_fifo_burst.sv
